// ===== src/lpmd_pkg.sv =====
`timescale 1ns / 1ps

package lpmd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ID_LIM_W = 9;
  localparam int unsigned LEN_W    = 31;
  localparam int unsigned PREFIX_W = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [BYTE_W-1:0]   LOWEST_ID_RST = 8'd0;
  localparam logic [ID_LIM_W-1:0] ID_LIMIT_RST  = 9'd9;
  localparam logic [LEN_W-1:0]    MAX_LEN_RST   = 31'd16393;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd2;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_PAYLOAD   = 3'd1,
    KIND_KEEPALIVE = 3'd2,
    KIND_BAD_ID    = 3'd3,
    KIND_OVERSIZE  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_PREFIX  = 2'd0,
    PH_ID      = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] message_id;
    logic [LEN_W-1:0]  message_length;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;
  } res_t;

endpackage

// ===== src/lpmd_in_if.sv =====
`timescale 1ns / 1ps

interface lpmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

// ===== src/lpmd_out_if.sv =====
`timescale 1ns / 1ps

interface lpmd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  message_id;
  logic [30:0] message_length;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, output kind, output message_id, output message_length,
                  output payload_byte, output last, input ready);
  modport sink (input valid, input kind, input message_id, input message_length,
                input payload_byte, input last, output ready);
endinterface

// ===== src/length_prefixed_message_deframer_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    stream_byte[7:0]
// out_ch    out  valid/ready    kind[2:0], message_id[7:0], message_length[30:0],
//                               payload_byte[7:0], last
// cfg_*     in   write enable   cfg_index[1:0], cfg_wdata[30:0]
//
// One byte is accepted per cycle while the result register is not stalled; each
// byte is held in the input register and its result, if any, is then registered
// in the result register, which drives result valid.
// Reset (rst_n low, synchronous) clears both stages and restarts at a length prefix.
// A stalled result register holds the input stage, bytes that give no result
// included.

module length_prefixed_message_deframer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  lpmd_in_if.sink                              in_ch,
  lpmd_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [lpmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lpmd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import lpmd_pkg::*;

  logic [BYTE_W-1:0]   lowest_id_r;
  logic [ID_LIM_W-1:0] id_limit_r;
  logic [LEN_W-1:0]    max_len_r;

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;

  phase_t              phase_r, phase_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic [PREFIX_W-1:0] length_r, length_nxt;
  logic [BYTE_W-1:0]   cur_id_r, cur_id_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;

  logic out_valid_r;
  res_t res_r;
  logic res_valid;
  res_t res;

  logic                s1_go;
  logic [PREFIX_W-1:0] shifted;
  logic [LEN_W-1:0]    rem_dec;
  logic                bad_id;

  assign s1_go        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || s1_go;

  assign shifted = {length_r[PREFIX_W-BYTE_W-1:0], in_byte_r};
  assign rem_dec = rem_r - 1'b1;
  assign bad_id  = (in_byte_r < lowest_id_r) || ({1'b0, in_byte_r} >= id_limit_r);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_id_r <= LOWEST_ID_RST;
      id_limit_r  <= ID_LIMIT_RST;
      max_len_r   <= MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOWEST_ID: lowest_id_r <= cfg_wdata[BYTE_W-1:0];
        CFG_ID_LIMIT:  id_limit_r  <= cfg_wdata[ID_LIM_W-1:0];
        CFG_MAX_LEN:   max_len_r   <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.stream_byte;
    end
  end

  // parser next state
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    length_nxt = length_r;
    cur_id_nxt = cur_id_r;
    rem_nxt    = rem_r;
    unique case (phase_r)
      PH_ID: begin
        if (bad_id) begin
          phase_nxt = PH_PREFIX;
          cnt_nxt   = 2'd0;
        end else begin
          cur_id_nxt = in_byte_r;
          if (rem_r == '0) begin
            phase_nxt = PH_PREFIX;
            cnt_nxt   = 2'd0;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = PH_PREFIX;
          cnt_nxt   = 2'd0;
        end
      end
      default: begin
        phase_nxt  = PH_PREFIX;
        length_nxt = shifted;
        if (cnt_r != 2'd3) begin
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          cnt_nxt = 2'd0;
          if (shifted != '0 && shifted <= {1'b0, max_len_r}) begin
            rem_nxt   = shifted[LEN_W-1:0] - 1'b1;
            phase_nxt = PH_ID;
          end
        end
      end
    endcase
  end

  // result for the byte in the input register
  always_comb begin
    res_valid          = 1'b0;
    res.kind           = KIND_HEADER;
    res.message_id     = '0;
    res.message_length = length_r[LEN_W-1:0];
    res.payload_byte   = '0;
    res.last           = 1'b1;
    unique case (phase_r)
      PH_ID: begin
        res_valid      = 1'b1;
        res.message_id = in_byte_r;
        if (bad_id) begin
          res.kind = KIND_BAD_ID;
        end else begin
          res.last = (rem_r == '0);
        end
      end
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.message_id   = cur_id_r;
        res.payload_byte = in_byte_r;
        res.last         = (rem_dec == '0);
      end
      default: begin
        res.message_length = shifted[LEN_W-1:0];
        if (cnt_r == 2'd3) begin
          if (shifted == '0) begin
            res_valid = 1'b1;
            res.kind  = KIND_KEEPALIVE;
          end else if (shifted > {1'b0, max_len_r}) begin
            res_valid = 1'b1;
            res.kind  = KIND_OVERSIZE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      cnt_r    <= 2'd0;
      length_r <= '0;
      cur_id_r <= '0;
      rem_r    <= '0;
    end else if (s1_go) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      length_r <= length_nxt;
      cur_id_r <= cur_id_nxt;
      rem_r    <= rem_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = res_r.kind;
  assign out_ch.message_id     = res_r.message_id;
  assign out_ch.message_length = res_r.message_length;
  assign out_ch.payload_byte   = res_r.payload_byte;
  assign out_ch.last           = res_r.last;

endmodule

// ===== src/lpmd_checker.sv =====
`timescale 1ns / 1ps

module lpmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [30:0] out_message_length,
  input logic [7:0]  out_payload_byte,
  input logic        out_last
);
  import lpmd_pkg::*;

  // hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_payload_byte))
    else $error("result item changed while stalled");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |-> out_payload_byte == 8'd0)
    else $error("payload byte nonzero outside payload item");

  a_keepalive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_KEEPALIVE |-> out_last && out_message_length == 31'd0)
    else $error("keep-alive item malformed");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_BAD_ID || out_kind == KIND_OVERSIZE) |-> out_last)
    else $error("error item not marked last");

  a_reset_idle: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind length_prefixed_message_deframer_unit lpmd_checker u_lpmd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_kind           (out_ch.kind),
  .out_message_length (out_ch.message_length),
  .out_payload_byte   (out_ch.payload_byte),
  .out_last           (out_ch.last)
);

// ===== tb/sv/tb_length_prefixed_message_deframer_unit.sv =====
`timescale 1ns / 1ps

module tb_length_prefixed_message_deframer_unit;
  import lpmd_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lpmd_in_if in_ch ();
  lpmd_out_if out_ch ();

  length_prefixed_message_deframer_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // register copies used for prediction
  logic [BYTE_W-1:0]   acc_low_id   = LOWEST_ID_RST;
  logic [ID_LIM_W-1:0] acc_id_limit = ID_LIMIT_RST;
  logic [LEN_W-1:0]    acc_max_len  = MAX_LEN_RST;

  // parser state as seen by the accepted byte stream
  phase_t              prs_phase = PH_PREFIX;
  logic [1:0]          prs_count = '0;
  logic [PREFIX_W-1:0] prs_len   = '0;
  logic [BYTE_W-1:0]   prs_id    = '0;
  logic [LEN_W-1:0]    prs_left  = '0;

  logic [7:0] wire_bytes[$];
  res_t       deframed_q[$];

  bit idling = 1'b1;
  int in_gap = 0;
  int out_stall = 0;
  int bytes_staged = 0;
  int bytes_accepted = 0;
  int records_checked = 0;
  int mismatch_count = 0;
  int settings_used = 1;

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("%0t deframer mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic void deframe_byte(input logic [7:0] b);
    res_t rec;
    bit   has_rec;
    has_rec = 1'b0;
    rec = '{kind: KIND_KEEPALIVE, message_id: '0, message_length: '0,
            payload_byte: '0, last: 1'b1};
    case (prs_phase)
      PH_ID: begin
        has_rec = 1'b1;
        rec.message_id = b;
        rec.message_length = prs_len[LEN_W-1:0];
        if (b < acc_low_id || {1'b0, b} >= acc_id_limit) begin
          rec.kind = KIND_BAD_ID;
          prs_phase = PH_PREFIX;
          prs_count = '0;
        end else begin
          prs_id = b;
          rec.kind = KIND_HEADER;
          rec.last = (prs_left == '0);
          if (rec.last) begin
            prs_phase = PH_PREFIX;
            prs_count = '0;
          end else begin
            prs_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        has_rec = 1'b1;
        prs_left = prs_left - 31'd1;
        rec.kind = KIND_PAYLOAD;
        rec.message_id = prs_id;
        rec.message_length = prs_len[LEN_W-1:0];
        rec.payload_byte = b;
        rec.last = (prs_left == '0);
        if (rec.last) begin
          prs_phase = PH_PREFIX;
          prs_count = '0;
        end
      end
      default: begin
        prs_phase = PH_PREFIX;
        prs_len = {prs_len[23:0], b};
        if (prs_count != 2'd3) begin
          prs_count = prs_count + 2'd1;
        end else begin
          prs_count = '0;
          has_rec = 1'b1;
          if (prs_len == '0) begin
            rec.kind = KIND_KEEPALIVE;
          end else if (prs_len > {1'b0, acc_max_len}) begin
            rec.kind = KIND_OVERSIZE;
            rec.message_length = prs_len[LEN_W-1:0];
          end else begin
            // good length: wait for the ID byte
            has_rec = 1'b0;
            prs_left = prs_len[LEN_W-1:0] - 31'd1;
            prs_phase = PH_ID;
          end
        end
      end
    endcase
    if (has_rec) deframed_q.push_back(rec);
  endfunction

  // byte feeder
  always @(posedge clk) begin : feed
    logic nv;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.stream_byte);
        void'(wire_bytes.pop_front());
        bytes_accepted++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        nv = 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
        nv = 1'b0;
      end else if (wire_bytes.size() == 0) begin
        nv = 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(1, 10) - 1;
        nv = 1'b0;
      end else begin
        nv = 1'b1;
      end
      in_ch.valid <= nv;
      if (nv) in_ch.stream_byte <= wire_bytes[0];
    end
  end

  // result checker
  always @(posedge clk) begin : watch
    res_t want;
    logic nr;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (deframed_q.size() == 0) begin
          flag_mismatch("result with nothing pending, kind", out_ch.kind, 0);
        end else begin
          want = deframed_q.pop_front();
          records_checked++;
          if (out_ch.kind !== want.kind)
            flag_mismatch("kind", out_ch.kind, want.kind);
          if (out_ch.message_id !== want.message_id)
            flag_mismatch("message_id", out_ch.message_id, want.message_id);
          if (out_ch.message_length !== want.message_length)
            flag_mismatch("message_length", out_ch.message_length, want.message_length);
          if (out_ch.payload_byte !== want.payload_byte)
            flag_mismatch("payload_byte", out_ch.payload_byte, want.payload_byte);
          if (out_ch.last !== want.last)
            flag_mismatch("last", out_ch.last, want.last);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        nr = 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(1, 10) - 1;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      out_ch.ready <= nr;
    end
  end

  function automatic void stage_byte(input logic [7:0] b);
    wire_bytes.push_back(b);
    bytes_staged++;
  endfunction

  function automatic void stage_word(input logic [31:0] w);
    stage_byte(w[31:24]);
    stage_byte(w[23:16]);
    stage_byte(w[15:8]);
    stage_byte(w[7:0]);
  endfunction

  // prefix and ID; payload follows only when the ID will be taken
  function automatic void stage_message(input logic [31:0] len, input logic [7:0] id);
    stage_word(len);
    stage_byte(id);
    if (id >= acc_low_id && {1'b0, id} < acc_id_limit)
      repeat (len - 1) stage_byte(8'($urandom_range(0, 255)));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_LOWEST_ID: acc_low_id = val[BYTE_W-1:0];
      CFG_ID_LIMIT:  acc_id_limit = val[ID_LIM_W-1:0];
      CFG_MAX_LEN:   acc_max_len = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] low, input logic [8:0] lim,
                            input logic [30:0] maxl);
    write_reg(CFG_LOWEST_ID, CFG_DATA_W'(low));
    write_reg(CFG_ID_LIMIT, CFG_DATA_W'(lim));
    write_reg(CFG_MAX_LEN, maxl);
    settings_used++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (wire_bytes.size() != 0 || in_ch.valid || deframed_q.size() != 0);
    // bytes without a result may still sit in the pipeline
    repeat (4) @(negedge clk);
  endtask

  // drain, then bring the parser back to a message boundary
  task automatic finish_setting();
    int guard;
    guard = 0;
    wait_drained();
    while ((prs_phase != PH_PREFIX || prs_count != 2'd0) && guard < 8) begin
      case (prs_phase)
        PH_ID: stage_byte(acc_low_id);
        PH_PAYLOAD: if (prs_left <= 31'd4096)
          repeat (prs_left) stage_byte(8'($urandom_range(0, 255)));
        default: repeat (4 - prs_count) stage_byte(8'h00);
      endcase
      wait_drained();
      guard++;
    end
  endtask

  task automatic queue_traffic(input int n, input bit noisy);
    int start;
    int pick;
    int cap;
    logic [31:0] len;
    logic [7:0] id;
    start = bytes_staged;
    while (bytes_staged - start < n) begin
      pick = $urandom_range(0, 99);
      cap = (acc_max_len < 31'd24) ? int'(acc_max_len) : 24;
      if (pick < 70 && cap > 0) begin
        len = $urandom_range(cap, 1);
        if (acc_id_limit > {1'b0, acc_low_id})
          id = 8'($urandom_range(int'(acc_id_limit) - 1, int'(acc_low_id)));
        else
          id = 8'($urandom_range(0, 255));
        stage_message(len, id);
      end else if (pick < 78) begin
        stage_word(32'd0);
      end else if (pick < 86) begin
        if (acc_max_len == 31'h7FFF_FFFF || $urandom_range(0, 1) == 0)
          len = $urandom | 32'h8000_0000;
        else
          len = 32'(acc_max_len) + 32'd1 + 32'($urandom_range(0, 300));
        stage_word(len);
      end else if (pick < 94 && cap > 0) begin
        len = $urandom_range(cap, 1);
        if (acc_low_id > 8'd0 && (acc_id_limit > 9'd255 || $urandom_range(0, 1) == 0))
          id = 8'($urandom_range(int'(acc_low_id) - 1, 0));
        else if (acc_id_limit <= 9'd255)
          id = 8'($urandom_range(255, int'(acc_id_limit)));
        else
          id = 8'($urandom_range(0, 255));
        stage_message(len, id);
      end else if (noisy) begin
        // stray bytes knock the parser off the frame boundary
        repeat ($urandom_range(1, 3)) stage_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : watchdog
    #(10_000_000);
    $display("tb_length_prefixed_message_deframer_unit NOT OK");
    $finish;
  end

  initial begin : run
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.stream_byte = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: keep-alive, length one at the top ID, short message
    // with extreme payload bytes, bad ID, top-bit and just-over lengths
    stage_word(32'd0);
    stage_word(32'd1);
    stage_byte(8'd8);
    stage_word(32'd3);
    stage_byte(8'd0);
    stage_byte(8'h00);
    stage_byte(8'hFF);
    stage_word(32'd1);
    stage_byte(8'd9);
    stage_word(32'hFFFF_FFFF);
    stage_word(32'd16394);
    finish_setting();
    queue_traffic(400, 1'b1);
    finish_setting();

    // every ID valid, largest length limit
    set_config(8'd0, 9'd256, 31'h7FFF_FFFF);
    queue_traffic(350, 1'b0);
    finish_setting();

    // only ID 255, every message length one
    set_config(8'd255, 9'd256, 31'd1);
    queue_traffic(300, 1'b1);
    finish_setting();

    // limit of zero rejects every ID
    set_config(8'd200, 9'd0, 31'd30);
    queue_traffic(250, 1'b1);
    finish_setting();

    // zero length limit flags every nonzero length
    set_config(8'd0, 9'd1, 31'd0);
    queue_traffic(200, 1'b1);
    finish_setting();

    // mid-range window at full rate
    set_config(8'd17, 9'd130, 31'd24);
    idling = 1'b0;
    queue_traffic(500, 1'b1);
    finish_setting();

    $display("covered %0d stream bytes over %0d register settings", bytes_accepted,
             settings_used);
    $display("checked %0d results, %0d mismatches", records_checked, mismatch_count);
    if (mismatch_count == 0)
      $display("tb_length_prefixed_message_deframer_unit OK");
    else
      $display("tb_length_prefixed_message_deframer_unit NOT OK");
    $finish;
  end

endmodule
